@@ hw/rtl/kfc_pkg.sv @@
`default_nettype none

package kfc_pkg;

	// Field widths fixed by the item layout
	localparam int FIELD_BITS = 16;
	localparam int Q_BITS     = 17;

	// Defaults for the top level parameters
	localparam int FRAME_BITS_DEF = 16;
	localparam int TICK_BITS_DEF  = 16;

	// Serial unit lengths: one multiplier bit and one quotient bit per cycle
	localparam int MUL_STEPS  = 16;
	localparam int QUOT_STEPS = 16;

	// Q1.16 one
	localparam logic [Q_BITS-1:0] Q_ONE = 17'h10000;

	// Opcodes
	localparam logic [1:0] OP_ADVANCE = 2'd0;
	localparam logic [1:0] OP_SET     = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_FRAME_PERIOD = 2'd0;
	localparam logic [1:0] REG_LAST_FRAME   = 2'd1;
	localparam logic [1:0] REG_LOOP_ENABLE  = 2'd2;

	// Register reset values
	localparam logic [FIELD_BITS-1:0] FRAME_PERIOD_RST = 16'd33;
	localparam logic [FIELD_BITS-1:0] LAST_FRAME_RST   = 16'd0;
	localparam logic                  LOOP_ENABLE_RST  = 1'b1;

	typedef struct packed {
		logic [1:0]            opcode;
		logic [FIELD_BITS-1:0] delta_ticks;
		logic [FIELD_BITS-1:0] frame_value;
		logic [FIELD_BITS-1:0] span_end;
	} kfc_cmd_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] frame_now;
		logic                  frame_advanced;
		logic                  at_last_frame;
		logic [Q_BITS-1:0]     progress_value;
	} kfc_res_t;

	// Handshake between the sequencer and a serial unit
	typedef struct packed {
		logic start;
		logic done;
	} kfc_unit_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/kfc_mul.sv @@
`default_nettype none

// Bit-serial dual multiplier: both products share the period as multiplier,
// scanned MSB first, one bit per cycle.
module kfc_mul import kfc_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [FIELD_BITS-1:0]   period,
	input  wire logic [FIELD_BITS-1:0]   mcand_a,
	input  wire logic [FIELD_BITS:0]     mcand_b,
	output logic                         done,
	output logic [2*FIELD_BITS-1:0]      prod_a,
	output logic [2*FIELD_BITS:0]        prod_b
);

	localparam int CNT_W = $clog2(MUL_STEPS);
	localparam int PA_W  = 2 * FIELD_BITS;
	localparam int PB_W  = 2 * FIELD_BITS + 1;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [FIELD_BITS-1:0] per_q;
	logic [FIELD_BITS-1:0] a_q;
	logic [FIELD_BITS:0]   b_q;
	logic [PA_W-1:0]       acc_a_q;
	logic [PB_W-1:0]       acc_b_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift-add datapath
	always_ff @(posedge clk) begin
		if (start) begin
			per_q   <= period;
			a_q     <= mcand_a;
			b_q     <= mcand_b;
			acc_a_q <= '0;
			acc_b_q <= '0;
		end else if (busy_q) begin
			per_q   <= {per_q[FIELD_BITS-2:0], 1'b0};
			acc_a_q <= {acc_a_q[PA_W-2:0], 1'b0} +
				(per_q[FIELD_BITS-1] ? PA_W'(a_q) : '0);
			acc_b_q <= {acc_b_q[PB_W-2:0], 1'b0} +
				(per_q[FIELD_BITS-1] ? PB_W'(b_q) : '0);
		end
	end

	assign done   = done_q;
	assign prod_a = acc_a_q;
	assign prod_b = acc_b_q;

endmodule

`default_nettype wire

@@ hw/rtl/kfc_div.sv @@
`default_nettype none

// Restoring divider giving a clamped Q1.16 ratio, one quotient bit per cycle.
// A check step first handles a zero divisor and a ratio of one or more.
module kfc_div import kfc_pkg::*; #(
	parameter int WIDTH = 34
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [WIDTH-1:0]  num,
	input  wire logic [WIDTH-1:0]  den,
	output logic                   done,
	output logic [Q_BITS-1:0]      quot
);

	localparam int CNT_W = $clog2(QUOT_STEPS);

	logic              busy_q;
	logic              chk_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WIDTH-1:0]  rem_q;
	logic [WIDTH-1:0]  den_q;
	logic [Q_BITS-1:0] quot_q;

	logic [WIDTH-1:0]  rem_sh;
	logic              fits;
	logic              den_zero;
	logic              sat;

	assign rem_sh   = {rem_q[WIDTH-2:0], 1'b0};
	assign fits     = rem_sh >= den_q;
	assign den_zero = den_q == '0;
	assign sat      = den_zero || rem_q >= den_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			chk_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				chk_q  <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (chk_q) begin
					chk_q <= 1'b0;
					if (sat) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(QUOT_STEPS - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (chk_q) begin
				if (den_zero) begin
					quot_q <= (rem_q != '0) ? Q_ONE : '0;
				end else if (sat) begin
					quot_q <= Q_ONE;
				end else begin
					quot_q <= '0;
				end
			end else begin
				rem_q  <= fits ? rem_sh - den_q : rem_sh;
				quot_q <= {quot_q[Q_BITS-2:0], fits};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

@@ hw/rtl/keyframe_clock_with_progress.sv @@
`default_nettype none

// Animation frame clock with span progress. Advance items add ticks to the
// elapsed count and step the frame once the count passes frame_period (wrap
// to zero past last_frame with looping on, else saturate); set items jump to
// a frame; query items return progress through a start..end span in Q1.16.
// Advance, set and the unused opcode go from idle straight to the finish
// state, which writes the result register once the result slot is free;
// the sequencer then returns to idle to take the next item. A query first
// runs the bit-serial multiplier that forms offset*period and span*period,
// then the restoring divider, whose range check can settle the ratio and
// skip the quotient steps, then the finish state. One item is worked on at
// a time; a new item is taken while the last result waits.
// Configuration writes are always ready and must only happen while idle.
module keyframe_clock_with_progress import kfc_pkg::*; #(
	parameter int FRAME_BITS = FRAME_BITS_DEF,
	parameter int TICK_BITS  = TICK_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// command channel
	input  wire logic                  cmd_valid,
	output logic                       cmd_stall,
	input  wire kfc_cmd_t              cmd,
	// result channel
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output kfc_res_t                   res,
	// configuration
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [FIELD_BITS-1:0] cfg_data
);

	localparam int EW = TICK_BITS + 2;
	localparam int CW = (EW > FIELD_BITS) ? EW : FIELD_BITS;
	localparam int LW = (FRAME_BITS + 1 > FIELD_BITS) ? FRAME_BITS + 1 : FIELD_BITS;
	localparam int FW = (FRAME_BITS > FIELD_BITS) ? FRAME_BITS : FIELD_BITS;
	localparam int DW = (TICK_BITS < FIELD_BITS) ? TICK_BITS : FIELD_BITS;
	localparam int NB = (FRAME_BITS < FIELD_BITS) ? FRAME_BITS : FIELD_BITS;
	localparam int NW = ((EW > 2 * FIELD_BITS) ? EW : 2 * FIELD_BITS) + 1;
	localparam int WW = (NW > 2 * FIELD_BITS + 2) ? NW : 2 * FIELD_BITS + 2;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]            state_q;
	logic [FIELD_BITS-1:0] period_q;
	logic [FIELD_BITS-1:0] last_q;
	logic                  loop_q;
	logic [FRAME_BITS-1:0] fc_q;
	logic [EW-1:0]         el_q;
	kfc_cmd_t              item_q;
	logic                  res_valid_q;
	kfc_res_t              res_q;

	logic                  accept;
	logic                  res_free;
	kfc_unit_ctl_t         mul_ctl;
	kfc_unit_ctl_t         div_ctl;
	logic [FW-1:0]         off_w;
	logic [FIELD_BITS:0]   span;
	logic [2*FIELD_BITS-1:0] prod_a;
	logic [2*FIELD_BITS:0] prod_b;
	logic [WW-1:0]         num_w;
	logic [WW-1:0]         den_w;
	logic [Q_BITS-1:0]     quot;

	logic [EW:0]           sum;
	logic [EW-1:0]         el_sat;
	logic [FRAME_BITS:0]   nxt;
	logic                  before_span;
	logic                  after_span;
	logic [FRAME_BITS-1:0] fc_d;
	logic [EW-1:0]         el_d;
	logic                  adv;
	logic [Q_BITS-1:0]     prog;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = state_q != ST_IDLE;
	assign res_free  = !res_valid_q || !res_stall;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= FRAME_PERIOD_RST;
			last_q   <= LAST_FRAME_RST;
			loop_q   <= LOOP_ENABLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_PERIOD: period_q <= cfg_data;
				REG_LAST_FRAME:   last_q   <= cfg_data;
				REG_LOOP_ENABLE:  loop_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Query operands, taken from the incoming item and the current frame
	assign off_w = FW'(fc_q) - FW'(cmd.frame_value);
	assign span  = (FIELD_BITS + 1)'(cmd.span_end) - (FIELD_BITS + 1)'(cmd.frame_value)
		+ (FIELD_BITS + 1)'(1);

	assign mul_ctl.start = accept && cmd.opcode == OP_QUERY;

	kfc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_ctl.start),
		.period  (period_q),
		.mcand_a (off_w[FIELD_BITS-1:0]),
		.mcand_b (span),
		.done    (mul_ctl.done),
		.prod_a  (prod_a),
		.prod_b  (prod_b)
	);

	assign num_w         = WW'(prod_a) + WW'(el_q);
	assign den_w         = WW'(prod_b);
	assign div_ctl.start = mul_ctl.done;

	kfc_div #(
		.WIDTH (WW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_ctl.start),
		.num    (num_w),
		.den    (den_w),
		.done   (div_ctl.done),
		.quot   (quot)
	);

	// Next state of the clock and the result of the held item
	assign sum         = {1'b0, el_q} + (EW + 1)'(item_q.delta_ticks[DW-1:0]);
	assign el_sat      = sum[EW] ? '1 : sum[EW-1:0];
	assign nxt         = {1'b0, fc_q} + (FRAME_BITS + 1)'(1);
	assign before_span = FW'(fc_q) < FW'(item_q.frame_value);
	assign after_span  = FW'(item_q.span_end) < FW'(fc_q);

	always_comb begin
		fc_d = fc_q;
		el_d = el_q;
		adv  = 1'b0;
		prog = '0;
		case (item_q.opcode)
			OP_ADVANCE: begin
				el_d = el_sat;
				if (CW'(period_q) < CW'(el_sat)) begin
					el_d = '0;
					adv  = 1'b1;
					if (loop_q && LW'(nxt) > LW'(last_q)) begin
						fc_d = '0;
					end else if (nxt[FRAME_BITS]) begin
						fc_d = '1;
					end else begin
						fc_d = nxt[FRAME_BITS-1:0];
					end
				end
			end
			OP_SET: begin
				fc_d = FRAME_BITS'(item_q.frame_value[NB-1:0]);
				el_d = '0;
			end
			OP_QUERY: begin
				if (before_span) begin
					prog = '0;
				end else if (after_span) begin
					prog = Q_ONE;
				end else begin
					prog = quot;
				end
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) begin
					state_q <= (cmd.opcode == OP_QUERY) ? ST_MUL : ST_FIN;
				end
				ST_MUL: if (mul_ctl.done) begin
					state_q <= ST_DIV;
				end
				ST_DIV: if (div_ctl.done) begin
					state_q <= ST_FIN;
				end
				ST_FIN: if (res_free) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Held item
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd;
		end
	end

	// Clock state, updated when the result is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= '0;
			el_q <= '0;
		end else if (state_q == ST_FIN && res_free) begin
			fc_q <= fc_d;
			el_q <= el_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && res_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && res_free) begin
			res_q.frame_now      <= FIELD_BITS'(fc_d[NB-1:0]);
			res_q.frame_advanced <= adv;
			res_q.at_last_frame  <= LW'(fc_d) == LW'(last_q);
			res_q.progress_value <= prog;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_ctl.done |-> state_q == ST_MUL)
		else $error("multiplier finished outside the multiply phase");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide phase");

	a_prog_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.progress_value <= Q_ONE)
		else $error("progress above one");

	a_adv_no_prog: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.frame_advanced |-> res.progress_value == '0)
		else $error("advance result carries progress");
`endif

endmodule

`default_nettype wire

@@ tb/tb_keyframe_clock_with_progress.sv @@
`timescale 1ns / 1ps

module tb_keyframe_clock_with_progress;
	import kfc_pkg::*;

	// No name in the package for the spare opcode
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SEGMENTS      = 6;
	localparam int SEG_ITEMS     = 117;
	localparam int SETTLE_CYCLES = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	kfc_cmd_t    cmd = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	kfc_res_t    res;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	keyframe_clock_with_progress dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Directed stimulus row: a register write or an item, with an optional typed status
	typedef struct {
		bit          is_cfg;
		logic [1:0]  idx;
		logic [15:0] data;
		kfc_cmd_t    c;
		bit          typed;
		kfc_res_t    r;
	} stim_row_t;

	// Mirror of the clock state and registers
	logic [15:0] clk_frame;
	logic [17:0] clk_elapsed;
	logic [15:0] cfg_period;
	logic [15:0] cfg_last;
	logic        cfg_loop;

	kfc_res_t    expected_status[$];
	stim_row_t   dir_rows[$];
	int          errors = 0;
	int          res_count = 0;
	int          cycle_cnt = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;

	// Span progress in Q1.16, clamped, floor of the ratio
	function automatic logic [16:0] span_q16(logic [15:0] s, logic [15:0] e);
		longint unsigned num, den, per;
		per = cfg_period;
		if (clk_frame < s)
			return 17'd0;
		if (e < clk_frame)
			return Q_ONE;
		den = (longint'(e) - longint'(s) + 1) * per;
		num = (longint'(clk_frame) - longint'(s)) * per + longint'(clk_elapsed);
		if (den == 0)
			return (num != 0) ? Q_ONE : 17'd0;
		if (num >= den)
			return Q_ONE;
		return 17'((num << 16) / den);
	endfunction

	// Apply one item to the mirror and return the status it should produce
	function automatic kfc_res_t step_clock(kfc_cmd_t c);
		kfc_res_t    r;
		logic [18:0] sum;
		logic [16:0] next;
		r = '0;
		case (c.opcode)
			OP_ADVANCE: begin
				sum = 19'(clk_elapsed) + 19'(c.delta_ticks);
				clk_elapsed = (sum > 19'h3ffff) ? 18'h3ffff : sum[17:0];
				if (clk_elapsed > 18'(cfg_period)) begin
					clk_elapsed = '0;
					r.frame_advanced = 1'b1;
					next = 17'(clk_frame) + 17'd1;
					if (cfg_loop && next > 17'(cfg_last))
						next = '0;
					else if (next > 17'hffff)
						next = 17'hffff;
					clk_frame = next[15:0];
				end
			end
			OP_SET: begin
				clk_frame   = c.frame_value;
				clk_elapsed = '0;
			end
			OP_QUERY: r.progress_value = span_q16(c.frame_value, c.span_end);
			default: ;
		endcase
		r.frame_now     = clk_frame;
		r.at_last_frame = (clk_frame == cfg_last);
		return r;
	endfunction

	// Random item, mostly aimed near the current frame and period boundary
	function automatic kfc_cmd_t rand_cmd();
		kfc_cmd_t c;
		int       sel, k;
		longint   gap;
		c.delta_ticks = 16'($urandom);
		c.frame_value = 16'($urandom);
		c.span_end    = 16'($urandom);
		sel = $urandom_range(0, 99);
		k   = $urandom_range(0, 9);
		if (sel < 45) begin
			c.opcode = OP_ADVANCE;
			gap = longint'(cfg_period) - longint'(clk_elapsed) + $urandom_range(0, 1);
			case (k)
				0: c.delta_ticks = 16'd0;
				1: c.delta_ticks = 16'hffff;
				2, 3: ;
				4, 5: c.delta_ticks = (gap > 65535) ? 16'hffff : (gap < 0 ? 16'd0 : 16'(gap));
				default: c.delta_ticks = 16'($urandom_range(0, cfg_period / 3 + 2));
			endcase
		end else if (sel < 60) begin
			c.opcode = OP_SET;
			case (k)
				0: c.frame_value = 16'hffff;
				1: c.frame_value = 16'd0;
				2: c.frame_value = cfg_last;
				3: c.frame_value = 16'hffff - 16'($urandom_range(0, 3));
				4, 5: ;
				default: c.frame_value = clk_frame + 16'($urandom_range(0, 4)) - 16'd2;
			endcase
		end else if (sel < 95) begin
			c.opcode = OP_QUERY;
			case (k)
				0, 1: ;
				2: c.frame_value = clk_frame + 16'($urandom_range(1, 3));
				3: c.span_end = clk_frame - 16'($urandom_range(1, 3));
				4: begin
					c.frame_value = 16'd0;
					c.span_end    = 16'hffff;
				end
				default: begin
					c.frame_value = clk_frame - 16'($urandom_range(0, 5));
					c.span_end    = clk_frame + 16'($urandom_range(0, 5));
				end
			endcase
		end else begin
			c.opcode = OP_UNUSED;
		end
		return c;
	endfunction

	function automatic stim_row_t item_row(logic [1:0] op, logic [15:0] d, logic [15:0] f,
		logic [15:0] e);
		stim_row_t row;
		row = '{default: '0};
		row.c = '{opcode: op, delta_ticks: d, frame_value: f, span_end: e};
		return row;
	endfunction

	function automatic stim_row_t typed_row(logic [1:0] op, logic [15:0] d, logic [15:0] f,
		logic [15:0] e, logic [15:0] fr, logic adv, logic atl, logic [16:0] prog);
		stim_row_t row;
		row = item_row(op, d, f, e);
		row.typed = 1'b1;
		row.r = '{frame_now: fr, frame_advanced: adv, at_last_frame: atl, progress_value: prog};
		return row;
	endfunction

	function automatic stim_row_t reg_row(logic [1:0] idx, logic [15:0] data);
		stim_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.idx    = idx;
		row.data   = data;
		return row;
	endfunction

	// Append one row to the directed table
	task automatic add_row(stim_row_t row);
		dir_rows.insert(dir_rows.size(), row);
	endtask

	task automatic report(string field, longint got, longint want);
		$display("mismatch in %s of result %0d: got %0d, expected %0d",
			field, res_count, got, want);
		errors++;
	endtask

	// Present one item and hold it until accepted
	task automatic send_cmd(kfc_cmd_t c);
		cfg_valid <= 1'b0;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	task automatic predict_and_send(kfc_cmd_t c, bit typed, kfc_res_t r);
		kfc_res_t pred;
		pred = step_clock(c);
		expected_status.insert(expected_status.size(), typed ? r : pred);
		send_cmd(c);
	endtask

	// Hold off the sender until every outstanding status is back
	task automatic drain();
		cmd_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
	endtask

	// Register write; valid stays up so back-to-back writes need no gap
	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_FRAME_PERIOD: cfg_period = data;
			REG_LAST_FRAME:   cfg_last = data;
			REG_LOOP_ENABLE:  cfg_loop = data[0];
			default: ;
		endcase
	endtask

	// Receiver stall
	always @(posedge clk)
		res_stall <= ($urandom_range(0, 99) < stall_pct);

	// Result checker
	always @(posedge clk) begin
		kfc_res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_status.size() == 0) begin
				$display("unexpected result %0d: frame %0d", res_count, res.frame_now);
				errors++;
			end else begin
				want = expected_status.pop_front();
				if (res.frame_now !== want.frame_now)
					report("frame_now", res.frame_now, want.frame_now);
				if (res.frame_advanced !== want.frame_advanced)
					report("frame_advanced", res.frame_advanced, want.frame_advanced);
				if (res.at_last_frame !== want.at_last_frame)
					report("at_last_frame", res.at_last_frame, want.at_last_frame);
				if (res.progress_value !== want.progress_value)
					report("progress_value", res.progress_value, want.progress_value);
			end
			res_count++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycle_cnt, expected_status.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		clk_frame   = '0;
		clk_elapsed = '0;
		cfg_period  = FRAME_PERIOD_RST;
		cfg_last    = LAST_FRAME_RST;
		cfg_loop    = LOOP_ENABLE_RST;

		// Default registers: period 33, last frame 0, looping
		add_row(typed_row(OP_QUERY, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 17'd0));
		// period reached but not exceeded
		add_row(typed_row(OP_ADVANCE, 16'd33, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 17'd0));
		add_row(typed_row(OP_ADVANCE, 16'd1, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 17'd0));
		add_row(typed_row(OP_UNUSED, 16'hffff, 16'hffff, 16'hffff,
			16'd0, 1'b0, 1'b1, 17'd0));
		add_row(typed_row(OP_SET, 16'd0, 16'hffff, 16'd0, 16'hffff, 1'b0, 1'b0, 17'd0));
		add_row(typed_row(OP_QUERY, 16'd0, 16'd0, 16'hffff,
			16'hffff, 1'b0, 1'b0, 17'd65535));
		add_row(typed_row(OP_QUERY, 16'd0, 16'd0, 16'd100,
			16'hffff, 1'b0, 1'b0, Q_ONE));
		add_row(item_row(OP_QUERY, 16'd0, 16'hffff, 16'hffff));
		add_row(typed_row(OP_SET, 16'd0, 16'd5, 16'd0, 16'd5, 1'b0, 1'b0, 17'd0));
		// frame before span start
		add_row(typed_row(OP_QUERY, 16'd0, 16'd10, 16'd20, 16'd5, 1'b0, 1'b0, 17'd0));
		// past last frame with looping wraps to zero
		add_row(typed_row(OP_ADVANCE, 16'hffff, 16'd0, 16'd0,
			16'd0, 1'b1, 1'b1, 17'd0));
		add_row(item_row(OP_SET, 16'd0, 16'd2, 16'd0));
		add_row(item_row(OP_ADVANCE, 16'd33, 16'd0, 16'd0));
		// elapsed equals period on the last span frame: exactly one
		add_row(typed_row(OP_QUERY, 16'd0, 16'd0, 16'd2, 16'd2, 1'b0, 1'b0, Q_ONE));
		add_row(item_row(OP_SET, 16'd0, 16'd1, 16'd0));
		add_row(item_row(OP_ADVANCE, 16'd10, 16'd0, 16'd0));
		add_row(item_row(OP_QUERY, 16'd0, 16'd0, 16'd3));
		// zero period with elapsed left over from before
		add_row(reg_row(REG_FRAME_PERIOD, 16'd0));
		add_row(typed_row(OP_QUERY, 16'd0, 16'd0, 16'd3, 16'd1, 1'b0, 1'b0, Q_ONE));
		add_row(typed_row(OP_ADVANCE, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 17'd0));
		add_row(typed_row(OP_QUERY, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 17'd0));
		// no looping, widest period and last frame: saturate at the top
		add_row(reg_row(REG_LAST_FRAME, 16'hffff));
		add_row(reg_row(REG_LOOP_ENABLE, 16'd0));
		add_row(reg_row(REG_FRAME_PERIOD, 16'hffff));
		add_row(typed_row(OP_SET, 16'd0, 16'hfffe, 16'd0,
			16'hfffe, 1'b0, 1'b0, 17'd0));
		add_row(typed_row(OP_ADVANCE, 16'hffff, 16'd0, 16'd0,
			16'hfffe, 1'b0, 1'b0, 17'd0));
		add_row(typed_row(OP_ADVANCE, 16'd1, 16'd0, 16'd0,
			16'hffff, 1'b1, 1'b1, 17'd0));
		add_row(item_row(OP_ADVANCE, 16'hffff, 16'd0, 16'd0));
		add_row(typed_row(OP_ADVANCE, 16'hffff, 16'd0, 16'd0,
			16'hffff, 1'b1, 1'b1, 17'd0));
		add_row(item_row(OP_QUERY, 16'd0, 16'hffff, 16'hffff));

		send_idle_pct = 30;
		stall_pct     = 82;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				drain();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				predict_and_send(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
			end
		end

		// Random segments, each under its own register setting
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain();
			case (seg)
				0: begin
					write_reg(REG_FRAME_PERIOD, 16'($urandom_range(1, 8)));
					write_reg(REG_LAST_FRAME, 16'($urandom_range(0, 12)));
					write_reg(REG_LOOP_ENABLE, 16'd1);
				end
				1: begin
					write_reg(REG_FRAME_PERIOD, 16'd0);
					write_reg(REG_LAST_FRAME, 16'hffff);
					write_reg(REG_LOOP_ENABLE, 16'd0);
				end
				2: begin
					write_reg(REG_FRAME_PERIOD, 16'hffff);
					write_reg(REG_LAST_FRAME, 16'd0);
					write_reg(REG_LOOP_ENABLE, 16'd1);
				end
				3: begin
					write_reg(REG_FRAME_PERIOD, 16'($urandom_range(1, 300)));
					write_reg(REG_LAST_FRAME, 16'($urandom));
					write_reg(REG_LOOP_ENABLE, 16'd0);
				end
				4: begin
					write_reg(REG_FRAME_PERIOD, 16'd1);
					write_reg(REG_LAST_FRAME, 16'($urandom_range(1, 40)));
					write_reg(REG_LOOP_ENABLE, 16'd1);
				end
				default: begin
					write_reg(REG_FRAME_PERIOD, 16'($urandom));
					write_reg(REG_LAST_FRAME, 16'($urandom_range(0, 200)));
					write_reg(REG_LOOP_ENABLE, 16'($urandom_range(0, 1)));
				end
			endcase
			case (seg / 2)
				0: begin
					send_idle_pct = 30;
					stall_pct     = 82;
				end
				1: begin
					send_idle_pct = 82;
					stall_pct     = 30;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
			endcase
			for (int n = 0; n < SEG_ITEMS; n++)
				predict_and_send(rand_cmd(), 1'b0, '0);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && expected_status.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
